[hdl/wrp_pkg.sv]
// Shared types and constants for the WAV RIFF header parser.
package wrp_pkg;

  localparam logic [31:0] TAG_RIFF    = 32'h5249_4646;
  localparam logic [31:0] TAG_FMT     = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA_LC = 32'h6461_7461;
  localparam logic [31:0] TAG_DATA_UC = 32'h4441_5441;
  localparam logic [31:0] TAG_END     = 32'h454E_4420;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] REQ_BITS     = 16'd16;
  localparam logic [15:0] REQ_CHANNELS = 16'd2;
  localparam logic [15:0] PCM_CODE     = 16'd1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FORMAT  = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NOT_RIFF  = 3'd1,
    ERR_FMT_AGAIN = 3'd2,
    ERR_NOT_PCM   = 3'd3,
    ERR_BITS      = 3'd4,
    ERR_CHANNELS  = 3'd5
  } err_t;

  typedef enum logic [8:0] {
    PH_RIFF     = 9'b000000001,
    PH_HEAD     = 9'b000000010,
    PH_ID       = 9'b000000100,
    PH_SIZE     = 9'b000001000,
    PH_FMT      = 9'b000010000,
    PH_SKIP     = 9'b000100000,
    PH_DATA     = 9'b001000000,
    PH_SKIP_END = 9'b010000000,
    PH_STOP     = 9'b100000000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        last_payload;
    err_t        error_code;
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] sample_freq;
    logic [31:0] bytes_per_sec;
    logic [15:0] frame_bytes;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
  } result_t;

endpackage

[hdl/wrp_parse.sv]
// Parser state and per-byte next-state and result logic.
module wrp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       byte_in,
  input  logic             start,
  output logic             res_valid,
  output wrp_pkg::result_t res
);

  wrp_pkg::phase_t phase, phase_next, ph;
  logic [3:0]   byte_count, byte_count_next, cnt;
  logic [31:0]  id_shift, id_shift_next, id;
  logic [31:0]  chunk_length, chunk_length_next, len;
  logic         format_seen, format_seen_next, seen;
  logic [127:0] fmt_capture, fmt_capture_next;
  logic [31:0]  id_sh, len_or;
  logic [15:0]  f_fmt, f_ch, f_bits;

  always_comb begin
    // a file start byte sees the reset state
    ph   = start ? wrp_pkg::PH_RIFF : phase;
    cnt  = start ? 4'd0 : byte_count;
    id   = start ? 32'd0 : id_shift;
    len  = start ? 32'd0 : chunk_length;
    seen = start ? 1'b0 : format_seen;

    id_sh  = {id[23:0], byte_in};
    len_or = len | ({24'd0, byte_in} << {cnt[1:0], 3'b000});
    fmt_capture_next = {byte_in, fmt_capture[127:8]};
    f_fmt  = fmt_capture_next[15:0];
    f_ch   = fmt_capture_next[31:16];
    f_bits = fmt_capture_next[127:112];

    phase_next        = ph;
    byte_count_next   = cnt;
    id_shift_next     = id;
    chunk_length_next = len;
    format_seen_next  = seen;
    res_valid         = 1'b0;
    res               = '0;

    unique case (ph)
      wrp_pkg::PH_RIFF: begin
        id_shift_next = id_sh;
        if (cnt == 4'd3) begin
          byte_count_next = 4'd0;
          if (id_sh != wrp_pkg::TAG_RIFF) begin
            res_valid      = 1'b1;
            res.kind       = wrp_pkg::KIND_ERROR;
            res.error_code = wrp_pkg::ERR_NOT_RIFF;
            phase_next     = wrp_pkg::PH_STOP;
          end else begin
            phase_next = wrp_pkg::PH_HEAD;
          end
        end else begin
          byte_count_next = cnt + 4'd1;
        end
      end
      wrp_pkg::PH_HEAD: begin
        if (cnt == 4'd7) begin
          byte_count_next = 4'd0;
          id_shift_next   = 32'd0;
          phase_next      = wrp_pkg::PH_ID;
        end else begin
          byte_count_next = cnt + 4'd1;
        end
      end
      wrp_pkg::PH_ID: begin
        id_shift_next = id_sh;
        if (cnt == 4'd3) begin
          byte_count_next   = 4'd0;
          chunk_length_next = 32'd0;
          phase_next        = wrp_pkg::PH_SIZE;
        end else begin
          byte_count_next = cnt + 4'd1;
        end
      end
      wrp_pkg::PH_SIZE: begin
        chunk_length_next = len_or;
        if (cnt == 4'd3) begin
          byte_count_next = 4'd0;
          if (id == wrp_pkg::TAG_FMT) begin
            if (seen) begin
              res_valid      = 1'b1;
              res.kind       = wrp_pkg::KIND_ERROR;
              res.error_code = wrp_pkg::ERR_FMT_AGAIN;
              phase_next     = wrp_pkg::PH_STOP;
            end else begin
              phase_next = wrp_pkg::PH_FMT;
            end
          end else if (id == wrp_pkg::TAG_DATA_LC) begin
            res_valid       = 1'b1;
            res.kind        = wrp_pkg::KIND_DATA;
            res.data_length = len_or;
            phase_next      = (len_or == 32'd0) ? wrp_pkg::PH_STOP : wrp_pkg::PH_DATA;
          end else if (id == wrp_pkg::TAG_DATA_UC || id == wrp_pkg::TAG_END) begin
            phase_next = (len_or == 32'd0) ? wrp_pkg::PH_STOP : wrp_pkg::PH_SKIP_END;
          end else begin
            id_shift_next = 32'd0;
            phase_next    = (len_or == 32'd0) ? wrp_pkg::PH_ID : wrp_pkg::PH_SKIP;
          end
        end else begin
          byte_count_next = cnt + 4'd1;
        end
      end
      wrp_pkg::PH_FMT: begin
        if (cnt == 4'd15) begin
          byte_count_next = 4'd0;
          if (f_fmt != wrp_pkg::PCM_CODE) begin
            res_valid      = 1'b1;
            res.kind       = wrp_pkg::KIND_ERROR;
            res.error_code = wrp_pkg::ERR_NOT_PCM;
            phase_next     = wrp_pkg::PH_STOP;
          end else if (f_bits != wrp_pkg::REQ_BITS) begin
            res_valid      = 1'b1;
            res.kind       = wrp_pkg::KIND_ERROR;
            res.error_code = wrp_pkg::ERR_BITS;
            phase_next     = wrp_pkg::PH_STOP;
          end else if (f_ch != wrp_pkg::REQ_CHANNELS) begin
            res_valid      = 1'b1;
            res.kind       = wrp_pkg::KIND_ERROR;
            res.error_code = wrp_pkg::ERR_CHANNELS;
            phase_next     = wrp_pkg::PH_STOP;
          end else begin
            format_seen_next  = 1'b1;
            res_valid         = 1'b1;
            res.kind          = wrp_pkg::KIND_FORMAT;
            res.format_code   = f_fmt;
            res.channel_count = f_ch;
            res.sample_freq   = fmt_capture_next[63:32];
            res.bytes_per_sec = fmt_capture_next[95:64];
            res.frame_bytes   = fmt_capture_next[111:96];
            res.sample_bits   = f_bits;
            id_shift_next     = 32'd0;
            if (len > wrp_pkg::FMT_BODY_LEN) begin
              chunk_length_next = len - wrp_pkg::FMT_BODY_LEN;
              phase_next        = wrp_pkg::PH_SKIP;
            end else begin
              chunk_length_next = 32'd0;
              phase_next        = wrp_pkg::PH_ID;
            end
          end
        end else begin
          byte_count_next = cnt + 4'd1;
        end
      end
      wrp_pkg::PH_SKIP: begin
        chunk_length_next = len - 32'd1;
        if (len == 32'd1) begin
          id_shift_next = 32'd0;
          phase_next    = wrp_pkg::PH_ID;
        end
      end
      wrp_pkg::PH_SKIP_END: begin
        chunk_length_next = len - 32'd1;
        if (len == 32'd1) phase_next = wrp_pkg::PH_STOP;
      end
      wrp_pkg::PH_DATA: begin
        chunk_length_next = len - 32'd1;
        res_valid         = 1'b1;
        res.kind          = wrp_pkg::KIND_PAYLOAD;
        res.payload_byte  = byte_in;
        res.last_payload  = (len == 32'd1);
        if (len == 32'd1) phase_next = wrp_pkg::PH_STOP;
      end
      wrp_pkg::PH_STOP: begin
        phase_next = wrp_pkg::PH_STOP;
      end
      default: begin
        phase_next = wrp_pkg::PH_STOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= wrp_pkg::PH_RIFF;
      byte_count   <= 4'd0;
      id_shift     <= 32'd0;
      chunk_length <= 32'd0;
      format_seen  <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      id_shift     <= id_shift_next;
      chunk_length <= chunk_length_next;
      format_seen  <= format_seen_next;
    end
  end

  // fmt body shifts in; sixteen bytes overwrite it fully before use
  always_ff @(posedge clk) begin
    if (fire && ph == wrp_pkg::PH_FMT) fmt_capture <= fmt_capture_next;
  end

endmodule

[hdl/wrp_out_buf.sv]
// Two-entry result queue: output register plus skid entry.
module wrp_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wrp_pkg::result_t push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_stall,
  output wrp_pkg::result_t head
);

  logic [1:0]       count, count_next;
  logic [1:0]       count_after_pop;
  logic             pop;
  wrp_pkg::result_t skid;

  assign out_valid       = (count != 2'd0);
  assign space           = (count != 2'd2);
  assign pop             = out_valid && !out_stall;
  assign count_after_pop = count - {1'b0, pop};
  assign count_next      = count_after_pop + {1'b0, push};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) head <= skid;
    if (push) begin
      if (count_after_pop == 2'd0) begin
        head <= push_data;
      end else begin
        skid <= push_data;
      end
    end
  end

endmodule

[hdl/wav_riff_header_parser_core.sv]
// WAV RIFF header parser: top level with input register, parser and result queue.
// Takes one file byte per beat and sustains one byte per clock cycle while the
// result queue has space; each byte is parsed from the input register and its
// result, if any, is written to the result queue and offered at the output. Each
// byte needs only a shift, compare and count in the parser stage. A two-entry
// result queue lets input continue while a result waits; input stalls only when
// both entries are full. No clearing pass follows reset. file_start high restarts
// the parser with that byte as the first byte of the RIFF tag.
module wav_riff_header_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic        last_payload,
  output logic [2:0]  error_code,
  output logic [15:0] format_code,
  output logic [15:0] channel_count,
  output logic [31:0] sample_freq,
  output logic [31:0] bytes_per_sec,
  output logic [15:0] frame_bytes,
  output logic [15:0] sample_bits,
  output logic [31:0] data_length
);

  logic             in_full;
  logic [7:0]       in_byte;
  logic             in_start;
  logic             space;
  logic             fire;
  logic             res_valid;
  wrp_pkg::result_t res;
  wrp_pkg::result_t head;

  assign fire     = in_full && space;
  assign in_stall = in_full && !space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte  <= data_byte;
      in_start <= file_start;
    end
  end

  wrp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .byte_in   (in_byte),
    .start     (in_start),
    .res_valid (res_valid),
    .res       (res)
  );

  wrp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign kind          = head.kind;
  assign payload_byte  = head.payload_byte;
  assign last_payload  = head.last_payload;
  assign error_code    = head.error_code;
  assign format_code   = head.format_code;
  assign channel_count = head.channel_count;
  assign sample_freq   = head.sample_freq;
  assign bytes_per_sec = head.bytes_per_sec;
  assign frame_bytes   = head.frame_bytes;
  assign sample_bits   = head.sample_bits;
  assign data_length   = head.data_length;

endmodule

[tb/sv/wav_riff_header_parser_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the WAV RIFF header parser core: directed and random files.
module wav_riff_header_parser_core_tb;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_BYTES = 100;
  localparam int          IDLE_PCT     = 16;
  localparam logic [31:0] FORM_WAVE    = 32'h5741_5645;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte    = 8'd0;
  logic        file_start   = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic        last_payload;
  logic [2:0]  error_code;
  logic [15:0] format_code;
  logic [15:0] channel_count;
  logic [31:0] sample_freq;
  logic [31:0] bytes_per_sec;
  logic [15:0] frame_bytes;
  logic [15:0] sample_bits;
  logic [31:0] data_length;

  int idle_pct    = IDLE_PCT;
  int bytes_taken = 0;
  int mismatches  = 0;
  int cycle_count = 0;

  // parser shadow state
  wrp_pkg::phase_t  hdr_phase    = wrp_pkg::PH_RIFF;
  logic [31:0]      hdr_count    = '0;
  logic [31:0]      hdr_id       = '0;
  logic [31:0]      hdr_len      = '0;
  logic             hdr_fmt_seen = 1'b0;
  logic [63:0]      hdr_fmt_words [2] = '{64'd0, 64'd0};
  wrp_pkg::result_t pending_results [$];

  logic [7:0]  file_bytes [$];

  wav_riff_header_parser_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .file_start    (file_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .payload_byte  (payload_byte),
    .last_payload  (last_payload),
    .error_code    (error_code),
    .format_code   (format_code),
    .channel_count (channel_count),
    .sample_freq   (sample_freq),
    .bytes_per_sec (bytes_per_sec),
    .frame_bytes   (frame_bytes),
    .sample_bits   (sample_bits),
    .data_length   (data_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[wav_riff_header_parser_core] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  task automatic restart_parser();
    hdr_phase        = wrp_pkg::PH_RIFF;
    hdr_count        = '0;
    hdr_id           = '0;
    hdr_len          = '0;
    hdr_fmt_seen     = 1'b0;
    hdr_fmt_words[0] = '0;
    hdr_fmt_words[1] = '0;
  endtask

  function automatic wrp_pkg::result_t empty_result(wrp_pkg::kind_t k);
    wrp_pkg::result_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  task automatic report_error(wrp_pkg::err_t code);
    wrp_pkg::result_t r;
    r            = empty_result(wrp_pkg::KIND_ERROR);
    r.error_code = code;
    pending_results.push_back(r);
    hdr_phase = wrp_pkg::PH_STOP;
  endtask

  task automatic parse_byte(logic [7:0] b, logic fs);
    wrp_pkg::result_t r;
    logic [3:0]       idx;
    logic [63:0]      w0, w1;
    if (fs) restart_parser();
    case (hdr_phase)
      wrp_pkg::PH_RIFF: begin
        hdr_id = {hdr_id[23:0], b};
        hdr_count++;
        if (hdr_count >= 4) begin
          hdr_count = '0;
          if (hdr_id != wrp_pkg::TAG_RIFF) report_error(wrp_pkg::ERR_NOT_RIFF);
          else hdr_phase = wrp_pkg::PH_HEAD;
        end
      end
      wrp_pkg::PH_HEAD: begin
        hdr_count++;
        if (hdr_count >= 8) begin
          hdr_count = '0;
          hdr_id    = '0;
          hdr_phase = wrp_pkg::PH_ID;
        end
      end
      wrp_pkg::PH_ID: begin
        hdr_id = {hdr_id[23:0], b};
        hdr_count++;
        if (hdr_count >= 4) begin
          hdr_count = '0;
          hdr_len   = '0;
          hdr_phase = wrp_pkg::PH_SIZE;
        end
      end
      wrp_pkg::PH_SIZE: begin
        // length is little-endian
        hdr_len = hdr_len | ({24'd0, b} << (hdr_count[1:0] * 8));
        hdr_count++;
        if (hdr_count >= 4) begin
          hdr_count = '0;
          if (hdr_id == wrp_pkg::TAG_FMT) begin
            if (hdr_fmt_seen) begin
              report_error(wrp_pkg::ERR_FMT_AGAIN);
            end else begin
              hdr_fmt_words[0] = '0;
              hdr_fmt_words[1] = '0;
              hdr_phase        = wrp_pkg::PH_FMT;
            end
          end else if (hdr_id == wrp_pkg::TAG_DATA_LC) begin
            r             = empty_result(wrp_pkg::KIND_DATA);
            r.data_length = hdr_len;
            pending_results.push_back(r);
            if (hdr_len == 0) hdr_phase = wrp_pkg::PH_STOP;
            else hdr_phase = wrp_pkg::PH_DATA;
          end else if (hdr_id == wrp_pkg::TAG_DATA_UC || hdr_id == wrp_pkg::TAG_END) begin
            if (hdr_len == 0) hdr_phase = wrp_pkg::PH_STOP;
            else hdr_phase = wrp_pkg::PH_SKIP_END;
          end else begin
            if (hdr_len == 0) hdr_phase = wrp_pkg::PH_ID;
            else hdr_phase = wrp_pkg::PH_SKIP;
            hdr_id = '0;
          end
        end
      end
      wrp_pkg::PH_FMT: begin
        // body is always 16 bytes, whatever the declared length
        idx = hdr_count[3:0];
        hdr_fmt_words[idx[3]] = hdr_fmt_words[idx[3]] | ({56'd0, b} << (idx[2:0] * 8));
        hdr_count++;
        if (hdr_count >= wrp_pkg::FMT_BODY_LEN) begin
          hdr_count = '0;
          w0 = hdr_fmt_words[0];
          w1 = hdr_fmt_words[1];
          if (w0[15:0] != wrp_pkg::PCM_CODE) begin
            report_error(wrp_pkg::ERR_NOT_PCM);
          end else if (w1[63:48] != wrp_pkg::REQ_BITS) begin
            report_error(wrp_pkg::ERR_BITS);
          end else if (w0[31:16] != wrp_pkg::REQ_CHANNELS) begin
            report_error(wrp_pkg::ERR_CHANNELS);
          end else begin
            hdr_fmt_seen    = 1'b1;
            r               = empty_result(wrp_pkg::KIND_FORMAT);
            r.format_code   = w0[15:0];
            r.channel_count = w0[31:16];
            r.sample_freq   = w0[63:32];
            r.bytes_per_sec = w1[31:0];
            r.frame_bytes   = w1[47:32];
            r.sample_bits   = w1[63:48];
            pending_results.push_back(r);
            hdr_id = '0;
            if (hdr_len > wrp_pkg::FMT_BODY_LEN) begin
              hdr_len   = hdr_len - wrp_pkg::FMT_BODY_LEN;
              hdr_phase = wrp_pkg::PH_SKIP;
            end else begin
              hdr_len   = '0;
              hdr_phase = wrp_pkg::PH_ID;
            end
          end
        end
      end
      wrp_pkg::PH_SKIP: begin
        hdr_len--;
        if (hdr_len == 0) begin
          hdr_id    = '0;
          hdr_phase = wrp_pkg::PH_ID;
        end
      end
      wrp_pkg::PH_SKIP_END: begin
        hdr_len--;
        if (hdr_len == 0) hdr_phase = wrp_pkg::PH_STOP;
      end
      wrp_pkg::PH_DATA: begin
        hdr_len--;
        r              = empty_result(wrp_pkg::KIND_PAYLOAD);
        r.payload_byte = b;
        r.last_payload = (hdr_len == 0);
        pending_results.push_back(r);
        if (hdr_len == 0) hdr_phase = wrp_pkg::PH_STOP;
      end
      default: begin
        hdr_phase = wrp_pkg::PH_STOP;
      end
    endcase
  endtask

  // ---------------------------------------------------------------- checking

  function automatic string describe(wrp_pkg::result_t r);
    return $sformatf({"kind=%0d byte=%h last=%b err=%0d fmt=%h ch=%h rate=%h ",
                      "brate=%h align=%h bits=%h size=%h"},
                     r.kind, r.payload_byte, r.last_payload, r.error_code,
                     r.format_code, r.channel_count, r.sample_freq, r.bytes_per_sec,
                     r.frame_bytes, r.sample_bits, r.data_length);
  endfunction

  task automatic log_mismatch(string why, wrp_pkg::result_t want, wrp_pkg::result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch, %s", $realtime, why);
      $display("  expected: %s", describe(want));
      $display("  actual:   %s", describe(seen));
    end
  endtask

  always begin : result_check
    wrp_pkg::result_t seen, want;
    bit               took;
    @(posedge clk);
    took               = !rst && out_valid && !out_stall;
    seen.kind          = wrp_pkg::kind_t'(kind);
    seen.payload_byte  = payload_byte;
    seen.last_payload  = last_payload;
    seen.error_code    = wrp_pkg::err_t'(error_code);
    seen.format_code   = format_code;
    seen.channel_count = channel_count;
    seen.sample_freq   = sample_freq;
    seen.bytes_per_sec = bytes_per_sec;
    seen.frame_bytes   = frame_bytes;
    seen.sample_bits   = sample_bits;
    seen.data_length   = data_length;
    // let the sender record this edge's beat first
    #1;
    if (took) begin
      if (pending_results.size() == 0) begin
        log_mismatch("result with none pending", '0, seen);
      end else begin
        want = pending_results.pop_front();
        if (seen.kind !== want.kind || seen.payload_byte !== want.payload_byte ||
            seen.last_payload !== want.last_payload ||
            seen.error_code !== want.error_code ||
            seen.format_code !== want.format_code ||
            seen.channel_count !== want.channel_count ||
            seen.sample_freq !== want.sample_freq ||
            seen.bytes_per_sec !== want.bytes_per_sec ||
            seen.frame_bytes !== want.frame_bytes ||
            seen.sample_bits !== want.sample_bits ||
            seen.data_length !== want.data_length)
          log_mismatch("field differs", want, seen);
      end
    end
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < idle_pct);
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(logic [7:0] b, logic fs);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    data_byte  = b;
    file_start = fs;
    do begin
      @(posedge clk);
    end while (in_stall);
    parse_byte(b, fs);
    bytes_taken++;
  endtask

  task automatic send_file(bit mark_start = 1'b1);
    foreach (file_bytes[i]) send_byte(file_bytes[i], mark_start && (i == 0));
    file_bytes.delete();
  endtask

  task automatic put_byte(logic [7:0] b);
    file_bytes.push_back(b);
  endtask

  task automatic put_be32(logic [31:0] v);
    put_byte(v[31:24]);
    put_byte(v[23:16]);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
  endtask

  task automatic put_le16(logic [15:0] v);
    put_byte(v[7:0]);
    put_byte(v[15:8]);
  endtask

  task automatic put_le32(logic [31:0] v);
    put_le16(v[15:0]);
    put_le16(v[31:16]);
  endtask

  task automatic put_riff_head(logic [31:0] tag = wrp_pkg::TAG_RIFF);
    put_be32(tag);
    put_le32($urandom);
    put_be32(FORM_WAVE);
  endtask

  task automatic put_chunk_head(logic [31:0] id, logic [31:0] len);
    put_be32(id);
    put_le32(len);
  endtask

  task automatic put_fmt(logic [31:0] len, logic [15:0] fmt, logic [15:0] ch,
                         logic [31:0] rate, logic [31:0] brate, logic [15:0] align,
                         logic [15:0] bits);
    put_chunk_head(wrp_pkg::TAG_FMT, len);
    put_le16(fmt);
    put_le16(ch);
    put_le32(rate);
    put_le32(brate);
    put_le16(align);
    put_le16(bits);
    if (len > wrp_pkg::FMT_BODY_LEN)
      repeat (len - wrp_pkg::FMT_BODY_LEN) put_byte(8'($urandom));
  endtask

  task automatic put_good_fmt(logic [31:0] len = wrp_pkg::FMT_BODY_LEN);
    put_fmt(len, wrp_pkg::PCM_CODE, wrp_pkg::REQ_CHANNELS, $urandom, $urandom,
            16'($urandom), wrp_pkg::REQ_BITS);
  endtask

  function automatic logic [31:0] pick_other_id();
    logic [31:0] id;
    do begin
      id = $urandom;
    end while (id == wrp_pkg::TAG_FMT || id == wrp_pkg::TAG_DATA_LC ||
               id == wrp_pkg::TAG_DATA_UC || id == wrp_pkg::TAG_END);
    return id;
  endfunction

  task automatic put_other(logic [31:0] len);
    put_chunk_head(pick_other_id(), len);
    repeat (len) put_byte(8'($urandom));
  endtask

  task automatic put_data(logic [31:0] len, logic [31:0] id = wrp_pkg::TAG_DATA_LC);
    put_chunk_head(id, len);
    repeat (len) put_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_bad_tag();
    // first file straight after reset, without file_start
    put_be32(32'h5249_4658);
    put_byte(8'hA5);
    send_file(1'b0);
    put_riff_head(wrp_pkg::TAG_RIFF ^ 32'h0000_0001);
    put_byte(8'hFF);
    send_file();
  endtask

  task automatic test_good_file();
    put_riff_head();
    put_fmt(wrp_pkg::FMT_BODY_LEN, wrp_pkg::PCM_CODE, wrp_pkg::REQ_CHANNELS,
            32'hFFFF_FFFF, 32'h0, 16'hFFFF, wrp_pkg::REQ_BITS);
    put_data(3);
    put_byte(8'h00);
    send_file();
  endtask

  task automatic test_fmt_checks();
    // all three wrong: PCM reported first
    put_riff_head();
    put_fmt(wrp_pkg::FMT_BODY_LEN, 16'hFFFF, 16'd1, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'd8);
    send_file();
    put_riff_head();
    put_fmt(wrp_pkg::FMT_BODY_LEN, wrp_pkg::PCM_CODE, 16'd1, $urandom, $urandom,
            16'($urandom), 16'hFFFF);
    send_file();
    put_riff_head();
    put_fmt(wrp_pkg::FMT_BODY_LEN, wrp_pkg::PCM_CODE, 16'd0, $urandom, $urandom,
            16'($urandom), wrp_pkg::REQ_BITS);
    put_byte(8'h5A);
    send_file();
  endtask

  task automatic test_fmt_twice();
    put_riff_head();
    put_good_fmt();
    put_good_fmt();
    put_byte(8'h11);
    send_file();
  endtask

  task automatic test_fmt_lengths();
    put_riff_head();
    put_good_fmt(32'd0);
    put_data(1);
    send_file();
    put_riff_head();
    put_good_fmt(32'd20);
    put_data(0);
    put_byte(8'h22);
    send_file();
  endtask

  task automatic test_other_chunks();
    // zero-length chunk, short chunk, then data with no fmt seen
    put_riff_head();
    put_other(0);
    put_other(2);
    put_data(2);
    put_byte(8'h33);
    send_file();
  endtask

  task automatic test_stop_chunks();
    put_riff_head();
    put_good_fmt();
    put_data(2, wrp_pkg::TAG_DATA_UC);
    put_data(2);
    send_file();
    put_riff_head();
    put_chunk_head(wrp_pkg::TAG_END, 32'd0);
    put_data(1);
    send_file();
  endtask

  task automatic test_huge_lengths();
    // cut short by the next file_start
    put_riff_head();
    put_chunk_head(wrp_pkg::TAG_DATA_LC, 32'hFFFF_FFFF);
    repeat (4) put_byte(8'($urandom));
    send_file();
    put_riff_head();
    put_chunk_head(pick_other_id(), 32'hFFFF_FFFF);
    repeat (3) put_byte(8'($urandom));
    send_file();
    put_riff_head();
    put_chunk_head(wrp_pkg::TAG_END, 32'hFFFF_FFFF);
    repeat (2) put_byte(8'($urandom));
    send_file();
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    put_riff_head();
    put_good_fmt();
    put_data(24);
    send_file();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    idle_pct = IDLE_PCT;
  endtask

  task automatic build_random_file();
    int unsigned mode, n;
    mode = $urandom_range(99);
    if (mode < 10) begin
      // noise
      if ($urandom_range(1)) put_be32(wrp_pkg::TAG_RIFF);
      n = $urandom_range(1, 12);
      repeat (n) put_byte(8'($urandom));
    end else begin
      if ($urandom_range(9) == 0)
        put_riff_head(wrp_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(31)));
      else put_riff_head();
      repeat ($urandom_range(2)) put_other($urandom_range(5));
      if ($urandom_range(9) != 0) begin
        n = $urandom_range(99);
        put_fmt((n < 70) ? wrp_pkg::FMT_BODY_LEN :
                (n < 85) ? $urandom_range(15) : $urandom_range(17, 22),
                ($urandom_range(9) == 0) ? 16'($urandom) : wrp_pkg::PCM_CODE,
                ($urandom_range(9) == 0) ? 16'($urandom_range(3)) : wrp_pkg::REQ_CHANNELS,
                $urandom, $urandom, 16'($urandom),
                ($urandom_range(9) == 0) ? 16'($urandom) : wrp_pkg::REQ_BITS);
        if ($urandom_range(6) == 0) put_good_fmt();
        repeat ($urandom_range(1)) put_other($urandom_range(4));
      end
      n = $urandom_range(99);
      if (n < 80) put_data(($urandom_range(6) == 0) ? $urandom_range(11, 40)
                                                    : $urandom_range(10));
      else if (n < 90) put_data($urandom_range(3), wrp_pkg::TAG_DATA_UC);
      else put_data($urandom_range(3), wrp_pkg::TAG_END);
      repeat ($urandom_range(2)) put_byte(8'($urandom));
      // broken file: cut off anywhere
      if (mode < 22) file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 1)];
    end
  endtask

  task automatic test_random_files();
    int start;
    start = bytes_taken;
    while (bytes_taken - start < RANDOM_BYTES) begin
      build_random_file();
      send_file();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_bad_tag();
    test_good_file();
    test_fmt_checks();
    test_fmt_twice();
    test_fmt_lengths();
    test_other_chunks();
    test_stop_chunks();
    test_huge_lengths();
    test_back_to_back();
    test_random_files();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    #2;
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[wav_riff_header_parser_core] OK");
    else
      $display("[wav_riff_header_parser_core] ERROR");
    $finish;
  end

endmodule

[wav_riff_header_parser_core.f]
hdl/wrp_pkg.sv
hdl/wrp_parse.sv
hdl/wrp_out_buf.sv
hdl/wav_riff_header_parser_core.sv
tb/sv/wav_riff_header_parser_core_tb.sv
